// ===== hw/rtl/rsfr_pkg.sv =====
package rsfr_pkg;

	localparam int unsigned WordW     = 32;
	localparam int unsigned LenW      = 30;
	localparam int unsigned ShortLenW = 9;
	localparam int unsigned ShortPosW = 22;
	localparam int unsigned CfgIdxW   = 2;

	typedef logic [WordW-1:0]   word_t;
	typedef logic [LenW-1:0]    len_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_START  = 2'd0;
	localparam cfg_idx_t CFG_END    = 2'd1;
	localparam cfg_idx_t CFG_OFFSET = 2'd2;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_POSWORD = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	// one queue entry: the words one input request gives
	typedef struct packed {
		logic  two;
		word_t w0;
		word_t w1;
	} rec_t;

endpackage

// ===== hw/rtl/rsfr_in_if.sv =====
interface rsfr_in_if;
	logic          valid;
	logic          ready;
	logic [31:0]   in_word;
	logic          final_word;

	modport source (output valid, output in_word, output final_word, input ready);
	modport sink   (input valid, input in_word, input final_word, output ready);
endinterface

// ===== hw/rtl/rsfr_out_if.sv =====
interface rsfr_out_if;
	logic          valid;
	logic          ready;
	logic [31:0]   out_word;
	logic          run_last;

	modport source (output valid, output out_word, output run_last, input ready);
	modport sink   (input valid, input out_word, input run_last, output ready);
endinterface

// ===== hw/rtl/rsfr_front.sv =====
module rsfr_front (
	input  logic              clk,
	input  logic              arst_n,
	rsfr_in_if.sink           in_ch,
	input  logic              cfg_we,
	input  rsfr_pkg::cfg_idx_t cfg_index,
	input  rsfr_pkg::word_t   cfg_data,
	input  logic              q_full,
	output logic              push,
	output rsfr_pkg::rec_t    push_ent
);

	rsfr_pkg::word_t  start_q, end_q, offset_q;
	rsfr_pkg::phase_t phase_q, phase_d;
	rsfr_pkg::len_t   pend_q, pend_d;
	rsfr_pkg::len_t   left_q, left_d;
	logic             keep_q, keep_d;
	logic             stopped_q, stopped_d;

	logic             accept;
	logic             begin_rec;
	rsfr_pkg::word_t  pos;
	rsfr_pkg::len_t   len;
	rsfr_pkg::word_t  new_pos;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			end_q    <= '0;
			offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rsfr_pkg::CFG_START:  start_q  <= cfg_data;
				rsfr_pkg::CFG_END:    end_q    <= cfg_data;
				rsfr_pkg::CFG_OFFSET: offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rsfr_pkg::PH_HEADER;
			pend_q    <= '0;
			left_q    <= '0;
			keep_q    <= 1'b0;
			stopped_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			pend_q    <= pend_d;
			left_q    <= left_d;
			keep_q    <= keep_d;
			stopped_q <= stopped_d;
		end
	end

	// header fields: long position word or short header
	always_comb begin
		if (phase_q == rsfr_pkg::PH_POSWORD) begin
			pos = in_ch.in_word;
			len = pend_q;
		end else begin
			pos = {{(rsfr_pkg::WordW - rsfr_pkg::ShortPosW){1'b0}},
				in_ch.in_word[rsfr_pkg::ShortPosW-1:0]};
			len = {{(rsfr_pkg::LenW - rsfr_pkg::ShortLenW){1'b0}},
				in_ch.in_word[30:rsfr_pkg::ShortPosW]};
		end
		new_pos = pos + offset_q;
	end

	always_comb begin
		phase_d      = phase_q;
		pend_d       = pend_q;
		left_d       = left_q;
		keep_d       = keep_q;
		stopped_d    = stopped_q;
		begin_rec    = 1'b0;
		push         = 1'b0;
		push_ent.two = 1'b0;
		push_ent.w0  = in_ch.in_word;
		push_ent.w1  = new_pos;

		if (accept) begin
			if (!stopped_q) begin
				case (phase_q)
					rsfr_pkg::PH_PAYLOAD: begin
						push   = keep_q;
						left_d = left_q - 1'b1;
						if (left_q == rsfr_pkg::LenW'(1)) begin
							phase_d = rsfr_pkg::PH_HEADER;
							keep_d  = 1'b0;
						end
					end
					rsfr_pkg::PH_POSWORD: begin
						begin_rec = 1'b1;
					end
					default: begin
						if (in_ch.in_word[31]) begin
							begin_rec = 1'b1;
						end else begin
							pend_d  = in_ch.in_word[rsfr_pkg::LenW-1:0];
							phase_d = rsfr_pkg::PH_POSWORD;
						end
					end
				endcase

				if (begin_rec) begin
					keep_d  = 1'b0;
					left_d  = len;
					phase_d = (len != '0) ? rsfr_pkg::PH_PAYLOAD : rsfr_pkg::PH_HEADER;
					if (pos < start_q) begin
						// skipped, payload consumed silently
					end else if (end_q != '0 && pos >= end_q) begin
						stopped_d = 1'b1;
						phase_d   = rsfr_pkg::PH_HEADER;
						left_d    = '0;
					end else if (len != '0) begin
						keep_d = 1'b1;
						push   = 1'b1;
						if (new_pos[31:rsfr_pkg::ShortPosW] == '0
								&& len[rsfr_pkg::LenW-1:rsfr_pkg::ShortLenW] == '0) begin
							push_ent.w0 = {1'b1, len[rsfr_pkg::ShortLenW-1:0],
								new_pos[rsfr_pkg::ShortPosW-1:0]};
						end else begin
							push_ent.two = 1'b1;
							push_ent.w0  = {2'b00, len};
						end
					end
				end
			end

			if (in_ch.final_word) begin
				phase_d   = rsfr_pkg::PH_HEADER;
				pend_d    = '0;
				left_d    = '0;
				keep_d    = 1'b0;
				stopped_d = 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/rsfr_queue.sv =====
module rsfr_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rsfr_pkg::rec_t push_ent,
	output logic           full,
	output logic           head_valid,
	output rsfr_pkg::rec_t head_ent,
	input  logic           pop
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	rsfr_pkg::rec_t    ent_q [DEPTH];
	logic [PtrW-1:0]   wr_q, rd_q;
	logic [CntW-1:0]   cnt_q;
	logic              do_push, do_pop;

	assign full       = (cnt_q == CntW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_ent   = ent_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/rsfr_back.sv =====
module rsfr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  rsfr_pkg::rec_t head_ent,
	output logic           pop,
	rsfr_out_if.source     out_ch
);

	logic            ov_q;
	logic            hi_q;
	rsfr_pkg::word_t word_q;
	logic            last_q;
	logic            load;

	assign load            = !ov_q || out_ch.ready;
	// pop once the last word of the head entry goes into the output register
	assign pop             = load && head_valid && (hi_q || !head_ent.two);
	assign out_ch.valid    = ov_q;
	assign out_ch.out_word = word_q;
	assign out_ch.run_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			hi_q <= 1'b0;
		end else if (load) begin
			ov_q <= head_valid;
			if (head_valid) begin
				hi_q <= head_ent.two && !hi_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			word_q <= hi_q ? head_ent.w1 : head_ent.w0;
			last_q <= hi_q || !head_ent.two;
		end
	end

endmodule

// ===== hw/rtl/record_stream_filter_rebase_top.sv =====
// channel   direction  payload               handshake
// in_ch     in         in_word, final_word   valid / ready
// out_ch    out        out_word, run_last    valid / ready
// cfg       in         cfg_index, cfg_data   cfg_we, no back-pressure
//
// one input word per cycle while the queue is not full; a kept record's long header
// gives two output words, so the output port sets the pace then.
// a request's words go into the queue, then from its head into the output register;
// the queue holds QueueDepth requests' worth of results between the two sides.
// arst_n clears parser, queue pointers and config; no clearing pass.
// input stalls only when the queue is full; output stalls hold the output register.
module record_stream_filter_rebase_top #(
	parameter int unsigned QueueDepth = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	rsfr_in_if.sink            in_ch,
	rsfr_out_if.source         out_ch,
	input  logic               cfg_we,
	input  rsfr_pkg::cfg_idx_t cfg_index,
	input  rsfr_pkg::word_t    cfg_data
);

	logic           q_full;
	logic           push;
	rsfr_pkg::rec_t push_ent;
	logic           head_valid;
	rsfr_pkg::rec_t head_ent;
	logic           pop;

	rsfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.push     (push),
		.push_ent (push_ent)
	);

	rsfr_queue #(
		.DEPTH(QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ent  (push_ent),
		.full      (q_full),
		.head_valid(head_valid),
		.head_ent  (head_ent),
		.pop       (pop)
	);

	rsfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_ent  (head_ent),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

// ===== hw/rtl/rsfr_checker.sv =====
module rsfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_word,
	input logic        run_last
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_word) && $stable(run_last))
		else $error("output payload changed while stalled");

	// a non-final word is always a long length word, its position word follows at once
	a_long_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !out_word[31])
		else $error("non-final word is not a long length word");

	a_long_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid && run_last)
		else $error("long header position word did not follow");

endmodule

bind record_stream_filter_rebase_top rsfr_checker u_rsfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_word (out_ch.out_word),
	.run_last (out_ch.run_last)
);
